// ===== rtl/timestamped_sample_ring_window_core_assert.svh =====
// Assertion macros for the timestamped sample ring window core.
// Expects i_clk and i_rst_n in the including module's scope.
`ifndef TIMESTAMPED_SAMPLE_RING_WINDOW_CORE_ASSERT_SVH
`define TIMESTAMPED_SAMPLE_RING_WINDOW_CORE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define TSRW_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define TSRW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tsrw_pkg.sv =====
`timescale 1ns / 1ps
// Package for the timestamped sample ring window core: widths, codes, payload
// structs, sequencer states and ring index helpers. No dependencies.
package tsrw_pkg;

    localparam int BUFFER_DEPTH = 64;
    localparam int IDX_W        = $clog2(BUFFER_DEPTH);
    localparam int POS_W        = IDX_W + 1;
    localparam int STAMP_W      = 48;
    localparam int WORD_W       = 32;
    localparam int SENSOR_WORDS = 9;
    localparam int SENSOR_W     = SENSOR_WORDS * WORD_W;

    typedef logic [IDX_W-1:0]           t_slot;
    typedef logic [POS_W-1:0]           t_pos;
    typedef logic signed [STAMP_W-1:0]  t_stamp;
    typedef logic signed [WORD_W-1:0]   t_word;
    typedef logic [SENSOR_W-1:0]        t_sensors;
    typedef logic [2:0]                 t_status;

    localparam t_slot  SLOT_LAST     = t_slot'(BUFFER_DEPTH - 1);
    localparam t_stamp STAMP_MAX     = {1'b0, {(STAMP_W-1){1'b1}}};
    localparam t_stamp STAMP_MIN     = {1'b1, {(STAMP_W-1){1'b0}}};
    localparam t_stamp ONE_SECOND_US = 48'sd1000000;

    // Result status codes
    localparam t_status STAT_OK         = 3'd0;
    localparam t_status STAT_NO_DATA    = 3'd1;
    localparam t_status STAT_MISSING    = 3'd2;
    localparam t_status STAT_DROPPED    = 3'd3;
    localparam t_status STAT_BAD_WINDOW = 3'd4;

    // Input item kinds
    localparam logic KIND_STORE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic   kind;
        t_stamp stamp_or_start;
        t_stamp window_end;
        t_word  accel_x;
        t_word  accel_y;
        t_word  accel_z;
        t_word  gyro_x;
        t_word  gyro_y;
        t_word  gyro_z;
        t_word  magnet_x;
        t_word  magnet_y;
        t_word  magnet_z;
    } t_item;

    typedef struct packed {
        t_stamp  row_stamp;
        t_word   row_accel_x;
        t_word   row_accel_y;
        t_word   row_accel_z;
        t_word   row_gyro_x;
        t_word   row_gyro_y;
        t_word   row_gyro_z;
        t_word   row_magnet_x;
        t_word   row_magnet_y;
        t_word   row_magnet_z;
        logic    last_row;
        t_status status;
    } t_result;

    typedef enum logic [3:0] {
        S_IDLE,
        S_STORE,
        S_QUERY,
        S_SMALL,
        S_SEEK,
        S_SEEK_CMP,
        S_CHKI,
        S_CHKI_CMP,
        S_EMIT,
        S_DRAIN
    } t_state;

    typedef enum logic {
        PH_START,
        PH_END
    } t_phase;

    // Search position (below twice the depth) to ring slot
    function automatic t_slot pos_to_slot(input t_pos p);
        if (p >= t_pos'(BUFFER_DEPTH)) begin
            return t_slot'(p - t_pos'(BUFFER_DEPTH));
        end
        return t_slot'(p);
    endfunction

    function automatic t_slot slot_inc(input t_slot s);
        if (s == SLOT_LAST) begin
            return '0;
        end
        return s + t_slot'(1);
    endfunction

    function automatic t_slot slot_dec(input t_slot s);
        if (s == '0) begin
            return SLOT_LAST;
        end
        return s - t_slot'(1);
    endfunction

    // Sensor word k of a packed row, word 0 in the top bits
    function automatic t_word sensor_word(input t_sensors v, input int k);
        return v[(SENSOR_WORDS-1-k)*WORD_W +: WORD_W];
    endfunction

endpackage

// ===== rtl/timestamped_sample_ring_window_core.sv =====
`timescale 1ns / 1ps
// Timestamped sample ring with window query: ring memories, search sequencer,
// row emit pipeline. Depends on tsrw_pkg and the assertion macro header.
//
// Channel     Ports                     Transfer
// ---------   -----------------------   ----------------------------------
// item in     i_start, o_busy, i_item   edge with i_start high, o_busy low
// result out  o_strobe, o_result        every edge with o_strobe high
// config      i_cfg_we, i_cfg_data      every edge with i_cfg_we high
//
// Store: capture, then write through the ring memory write port.
// Query: search for the window start, then if needed for its end, then one row
// per cycle through the read port registers and the result register. The search
// probes in a loop of S_SEEK and S_SEEK_CMP on the registered stamp memory
// read port and the one shared compare unit; rows are read on that port.
// Reset clears valid marks, indexes and correction at once; no clearing pass.
// Results are one-cycle strobes; the receiver cannot stall them.
module timestamped_sample_ring_window_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  tsrw_pkg::t_item   i_item,
    output logic              o_strobe,
    output tsrw_pkg::t_result o_result,
    input  logic              i_cfg_we,
    input  tsrw_pkg::t_stamp  i_cfg_data
);
    import tsrw_pkg::*;

    // Control registers
    t_state               r_state, n_state;
    t_slot                r_wi, n_wi;
    t_slot                r_ri, n_ri;
    logic [BUFFER_DEPTH-1:0] r_valid;
    t_stamp               r_corr;
    logic                 r_strobe, n_strobe;
    logic                 r_rd_row;

    // Datapath registers
    t_item                r_item;
    t_pos                 r_left, n_left;
    t_pos                 r_right, n_right;
    t_stamp               r_key, n_key;
    t_phase               r_phase, n_phase;
    logic                 r_t1_small, n_t1_small;
    t_slot                r_i2, n_i2;
    t_slot                r_row_slot, n_row_slot;
    t_result              r_result, n_result;
    t_stamp               r_rd_stamp;
    t_sensors             r_rd_sensor;
    logic                 r_rd_vld;
    logic                 r_rd_last;

    // Ring memories
    t_stamp               r_stamp_mem  [BUFFER_DEPTH];
    t_sensors             r_sensor_mem [BUFFER_DEPTH];

    // Combinational helpers
    t_pos                 pos_end;
    logic [POS_W:0]       sum_lr;
    t_pos                 mid;
    logic                 seek_done;
    t_stamp               cmp_a, cmp_b;
    logic                 cmp_ge;
    logic                 hit;
    t_slot                i_slot, i_prev, i1;
    logic                 use_i, v_i1, no_data, missing, dropped;
    t_slot                mem_addr;
    logic                 mem_we;
    logic [STAMP_W:0]     sum_st;
    t_stamp               sat_stamp;
    t_sensors             in_sensors;
    logic                 stat_fire;
    t_status              stat_code;

    assign o_busy   = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // Search bounds and midpoint
    assign pos_end   = {1'b0, r_wi} + t_pos'(BUFFER_DEPTH - 1);
    assign sum_lr    = {1'b0, r_left} + {1'b0, r_right};
    assign mid       = sum_lr[POS_W:1];
    assign seek_done = (r_left == r_right);

    // Shared signed compare unit
    always_comb begin
        case (r_state)
            S_QUERY: begin
                cmp_a = r_item.window_end;
                cmp_b = r_item.stamp_or_start;
            end
            S_SMALL: begin
                cmp_a = ONE_SECOND_US;
                cmp_b = r_item.stamp_or_start;
            end
            default: begin
                cmp_a = r_rd_stamp;
                cmp_b = r_key;
            end
        endcase
    end
    assign cmp_ge = (cmp_a >= cmp_b);
    assign hit    = r_rd_vld && cmp_ge;

    // First-row selection after the start search
    assign i_slot  = pos_to_slot(r_left);
    assign i_prev  = slot_dec(i_slot);
    assign use_i   = r_t1_small && !r_valid[i_prev];
    assign i1      = use_i ? i_slot : i_prev;
    assign v_i1    = use_i ? r_rd_vld : r_valid[i_prev];
    assign no_data = !hit && !v_i1;
    assign missing = (i_slot == r_wi);
    assign dropped = (r_wi == r_ri);

    // Saturating stamp correction
    assign sum_st = {r_corr[STAMP_W-1], r_corr}
                  + {r_item.stamp_or_start[STAMP_W-1], r_item.stamp_or_start};
    always_comb begin
        case (sum_st[STAMP_W:STAMP_W-1])
            2'b01:   sat_stamp = STAMP_MAX;
            2'b10:   sat_stamp = STAMP_MIN;
            default: sat_stamp = sum_st[STAMP_W-1:0];
        endcase
    end
    assign in_sensors = {r_item.accel_x, r_item.accel_y, r_item.accel_z,
                         r_item.gyro_x, r_item.gyro_y, r_item.gyro_z,
                         r_item.magnet_x, r_item.magnet_y, r_item.magnet_z};

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = (i_item.kind == KIND_STORE) ? S_STORE : S_QUERY;
                end
            end
            S_STORE: n_state = S_IDLE;
            S_QUERY: n_state = cmp_ge ? S_SMALL : S_IDLE;
            S_SMALL: n_state = S_SEEK;
            S_SEEK: begin
                if (!seek_done) begin
                    n_state = S_SEEK_CMP;
                end else if (r_phase == PH_START) begin
                    n_state = S_CHKI;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_SEEK_CMP: n_state = S_SEEK;
            S_CHKI:     n_state = S_CHKI_CMP;
            S_CHKI_CMP: begin
                if (no_data || missing) begin
                    n_state = S_IDLE;
                end else if (!hit) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_SEEK;
                end
            end
            S_EMIT:  n_state = (r_row_slot == r_i2) ? S_DRAIN : S_EMIT;
            S_DRAIN: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs and datapath next values
    always_comb begin
        n_wi       = r_wi;
        n_ri       = r_ri;
        n_left     = r_left;
        n_right    = r_right;
        n_key      = r_key;
        n_phase    = r_phase;
        n_t1_small = r_t1_small;
        n_i2       = r_i2;
        n_row_slot = r_row_slot;
        mem_addr   = r_row_slot;
        mem_we     = 1'b0;
        stat_fire  = 1'b0;
        stat_code  = STAT_OK;
        case (r_state)
            S_STORE: begin
                if (dropped) begin
                    stat_fire = 1'b1;
                    stat_code = STAT_DROPPED;
                end else begin
                    mem_we = 1'b1;
                    n_wi   = slot_inc(r_wi);
                end
            end
            S_QUERY: begin
                if (!cmp_ge) begin
                    stat_fire = 1'b1;
                    stat_code = STAT_BAD_WINDOW;
                end
            end
            S_SMALL: begin
                n_t1_small = cmp_ge;
                n_left     = {1'b0, r_wi};
                n_right    = pos_end;
                n_key      = r_item.stamp_or_start;
                n_phase    = PH_START;
            end
            S_SEEK: begin
                mem_addr = pos_to_slot(mid);
                if (seek_done && r_phase == PH_END) begin
                    n_i2 = pos_to_slot(r_left);
                end
            end
            S_SEEK_CMP: begin
                if (hit) begin
                    n_right = mid;
                end else begin
                    n_left = mid + t_pos'(1);
                end
            end
            S_CHKI: begin
                mem_addr = i_slot;
            end
            S_CHKI_CMP: begin
                if (no_data) begin
                    stat_fire = 1'b1;
                    stat_code = STAT_NO_DATA;
                end else if (missing) begin
                    stat_fire = 1'b1;
                    stat_code = STAT_MISSING;
                end else begin
                    n_ri       = i1;
                    n_row_slot = i1;
                    if (!hit) begin
                        n_i2 = i1;
                    end else begin
                        n_right = pos_end;
                        n_key   = r_item.window_end;
                        n_phase = PH_END;
                    end
                end
            end
            S_EMIT: begin
                mem_addr = r_row_slot;
                if (r_row_slot != r_i2) begin
                    n_row_slot = slot_inc(r_row_slot);
                end
            end
            default: begin
            end
        endcase
    end

    // Result register: a row from the read stage, or a status-only result
    always_comb begin
        n_strobe = r_rd_row || stat_fire;
        n_result = '0;
        if (r_rd_row) begin
            if (r_rd_vld) begin
                n_result.row_stamp    = r_rd_stamp;
                n_result.row_accel_x  = sensor_word(r_rd_sensor, 0);
                n_result.row_accel_y  = sensor_word(r_rd_sensor, 1);
                n_result.row_accel_z  = sensor_word(r_rd_sensor, 2);
                n_result.row_gyro_x   = sensor_word(r_rd_sensor, 3);
                n_result.row_gyro_y   = sensor_word(r_rd_sensor, 4);
                n_result.row_gyro_z   = sensor_word(r_rd_sensor, 5);
                n_result.row_magnet_x = sensor_word(r_rd_sensor, 6);
                n_result.row_magnet_y = sensor_word(r_rd_sensor, 7);
                n_result.row_magnet_z = sensor_word(r_rd_sensor, 8);
            end
            n_result.last_row = r_rd_last;
            n_result.status   = STAT_OK;
        end else begin
            n_result.last_row = 1'b1;
            n_result.status   = stat_code;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_wi     <= '0;
            r_ri     <= SLOT_LAST;
            r_valid  <= '0;
            r_corr   <= '0;
            r_strobe <= 1'b0;
            r_rd_row <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_wi     <= n_wi;
            r_ri     <= n_ri;
            r_strobe <= n_strobe;
            r_rd_row <= (r_state == S_EMIT);
            if (mem_we) begin
                r_valid[r_wi] <= 1'b1;
            end
            if (i_cfg_we) begin
                r_corr <= i_cfg_data;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_item <= i_item;
        end
        r_left     <= n_left;
        r_right    <= n_right;
        r_key      <= n_key;
        r_phase    <= n_phase;
        r_t1_small <= n_t1_small;
        r_i2       <= n_i2;
        r_row_slot <= n_row_slot;
        r_result   <= n_result;
        r_rd_vld   <= r_valid[mem_addr];
        r_rd_last  <= (r_row_slot == r_i2);
    end

    // Ring memories: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_stamp_mem[r_wi]  <= sat_stamp;
            r_sensor_mem[r_wi] <= in_sensors;
        end
        r_rd_stamp  <= r_stamp_mem[mem_addr];
        r_rd_sensor <= r_sensor_mem[mem_addr];
    end

    // Assertions
    `include "timestamped_sample_ring_window_core_assert.svh"

    `TSRW_ASSERT_NEXT(a_accept_busy, i_start && !o_busy, o_busy, "busy not raised after transfer")
    `TSRW_ASSERT_NEXT(a_rows_contig, o_strobe && !o_result.last_row, o_strobe, "row run broken")
    `TSRW_ASSERT_IMPL(a_status_last, o_strobe && (o_result.status != STAT_OK), o_result.last_row, "status result not last")

endmodule

// ===== tb/timestamped_sample_ring_window_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for timestamped_sample_ring_window_core: a ring predictor
// scores every row transfer against the design. Depends on tsrw_pkg and the RTL only.
module timestamped_sample_ring_window_core_tb;
    import tsrw_pkg::*;

    localparam int RANDOM_ITEMS = 470;
    localparam int PHASES       = 6;
    localparam int STORE_SETTLE = 8;     // margin for a trailing store write-back
    localparam int END_SETTLE   = 150;   // search plus a full ring of rows
    localparam int QUIET_LIMIT  = 3000;  // cycles with no item or register transfer
    localparam int PRINT_CAP    = 200;

    logic    i_clk;
    logic    i_rst_n;
    logic    i_start;
    logic    o_busy;
    t_item   i_item;
    logic    o_strobe;
    t_result o_result;
    logic    i_cfg_we;
    t_stamp  i_cfg_data;

    timestamped_sample_ring_window_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .o_busy     (o_busy),
        .i_item     (i_item),
        .o_strobe   (o_strobe),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    // Ring predictor plus queue of rows still owed by the design
    class ring_window_board;
        t_stamp   stamp_mem [BUFFER_DEPTH];
        t_sensors sensor_mem[BUFFER_DEPTH];
        bit       filled    [BUFFER_DEPTH];
        int       wr_slot;
        int       rd_slot;
        t_stamp   correction;
        t_result  rows_due[$];
        int       errors;

        function new();
            foreach (filled[s]) begin
                filled[s]     = 1'b0;
                stamp_mem[s]  = '0;
                sensor_mem[s] = '0;
            end
            wr_slot    = 0;
            rd_slot    = BUFFER_DEPTH - 1;
            correction = '0;
            errors     = 0;
        endfunction

        task report(string what);
            errors++;
            if (errors <= PRINT_CAP) $display("[%0t] MISMATCH: %s", $time, what);
        endtask

        // A slot reaches t when it holds a sample stamped at or after t
        function bit reaches(int pos, t_stamp t);
            return filled[pos % BUFFER_DEPTH] && (stamp_mem[pos % BUFFER_DEPTH] >= t);
        endfunction

        function int seek(int lo, int hi, t_stamp t);
            int mid;
            while (lo != hi) begin
                mid = (lo + hi) / 2;
                if (reaches(mid, t)) hi = mid;
                else lo = mid + 1;
            end
            return lo;
        endfunction

        function void push_status(t_status code);
            t_result r;
            r          = '0;
            r.last_row = 1'b1;
            r.status   = code;
            rows_due.push_back(r);
        endfunction

        // Empty slots come out as all-zero rows
        function void push_row(int slot, bit is_last);
            t_result r;
            r = '0;
            if (filled[slot]) begin
                r.row_stamp = stamp_mem[slot];
                {r.row_accel_x, r.row_accel_y, r.row_accel_z,
                 r.row_gyro_x, r.row_gyro_y, r.row_gyro_z,
                 r.row_magnet_x, r.row_magnet_y, r.row_magnet_z} = sensor_mem[slot];
            end
            r.last_row = is_last;
            r.status   = STAT_OK;
            rows_due.push_back(r);
        endfunction

        function void note_item(t_item it);
            t_stamp t1;
            t_stamp t2;
            longint sum;
            int     first_pos;
            int     hit;
            int     lead;
            int     tail;
            int     count;
            bit     past_all;
            t1 = it.stamp_or_start;
            t2 = it.window_end;

            // Store: dropped when the reader still holds the write slot
            if (it.kind == KIND_STORE) begin
                if (wr_slot == rd_slot) begin
                    push_status(STAT_DROPPED);
                    return;
                end
                sum = longint'(t1) + longint'(correction);
                if (sum > longint'(STAMP_MAX)) sum = longint'(STAMP_MAX);
                if (sum < longint'(STAMP_MIN)) sum = longint'(STAMP_MIN);
                stamp_mem[wr_slot]  = t_stamp'(sum);
                sensor_mem[wr_slot] = {it.accel_x, it.accel_y, it.accel_z,
                                       it.gyro_x, it.gyro_y, it.gyro_z,
                                       it.magnet_x, it.magnet_y, it.magnet_z};
                filled[wr_slot] = 1'b1;
                wr_slot = (wr_slot + 1) % BUFFER_DEPTH;
                return;
            end

            if (t1 > t2) begin
                push_status(STAT_BAD_WINDOW);
                return;
            end

            // Search oldest to newest for the window start
            first_pos = seek(wr_slot, wr_slot + BUFFER_DEPTH - 1, t1);
            hit       = first_pos % BUFFER_DEPTH;
            lead      = (hit + BUFFER_DEPTH - 1) % BUFFER_DEPTH;
            if (t1 <= ONE_SECOND_US && !filled[lead]) lead = hit;
            past_all = !reaches(hit, t1);
            if (past_all && !filled[lead]) begin
                push_status(STAT_NO_DATA);
                return;
            end
            if (hit == wr_slot) begin
                push_status(STAT_MISSING);
                return;
            end

            if (past_all) tail = lead;
            else tail = seek(first_pos, wr_slot + BUFFER_DEPTH - 1, t2) % BUFFER_DEPTH;
            rd_slot = lead;
            count   = (tail + BUFFER_DEPTH - lead) % BUFFER_DEPTH + 1;
            for (int n = 0; n < count; n++) begin
                push_row((lead + n) % BUFFER_DEPTH, n == count - 1);
            end
        endfunction

        task match_field(string name, logic [63:0] got, logic [63:0] want);
            if (got !== want) report($sformatf("%s got %h expected %h", name, got, want));
        endtask

        task check_row(t_result got);
            t_result want;
            if (rows_due.size() == 0) begin
                report($sformatf("row with nothing expected, stamp %h status %0d",
                                 got.row_stamp, got.status));
                return;
            end
            want = rows_due.pop_front();
            match_field("row_stamp", got.row_stamp, want.row_stamp);
            match_field("row_accel_x", got.row_accel_x, want.row_accel_x);
            match_field("row_accel_y", got.row_accel_y, want.row_accel_y);
            match_field("row_accel_z", got.row_accel_z, want.row_accel_z);
            match_field("row_gyro_x", got.row_gyro_x, want.row_gyro_x);
            match_field("row_gyro_y", got.row_gyro_y, want.row_gyro_y);
            match_field("row_gyro_z", got.row_gyro_z, want.row_gyro_z);
            match_field("row_magnet_x", got.row_magnet_x, want.row_magnet_x);
            match_field("row_magnet_y", got.row_magnet_y, want.row_magnet_y);
            match_field("row_magnet_z", got.row_magnet_z, want.row_magnet_z);
            match_field("last_row", got.last_row, want.last_row);
            match_field("status", got.status, want.status);
        endtask
    endclass

    ring_window_board board;
    int               burst_left;
    int               items_sent;
    longint           raw_next;
    int               quiet_cycles;

    function automatic t_stamp to_stamp(longint v);
        if (v > longint'(STAMP_MAX)) return STAMP_MAX;
        if (v < longint'(STAMP_MIN)) return STAMP_MIN;
        return t_stamp'(v);
    endfunction

    function automatic t_stamp rand_stamp();
        return t_stamp'({$urandom, $urandom});
    endfunction

    function automatic t_sensors rand_words();
        t_sensors w;
        for (int k = 0; k < SENSOR_WORDS; k++) w[k*WORD_W +: WORD_W] = $urandom;
        return w;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Sender: bursts of random length, random gaps between them
    task automatic send_item(logic kind, t_stamp a, t_stamp b, t_sensors words);
        t_item it;
        int    gap;
        it.kind           = kind;
        it.stamp_or_start = a;
        it.window_end     = b;
        {it.accel_x, it.accel_y, it.accel_z, it.gyro_x, it.gyro_y, it.gyro_z,
         it.magnet_x, it.magnet_y, it.magnet_z} = words;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0) begin
                i_start <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_start <= 1'b1;
        i_item  <= it;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        @(negedge i_clk);
        items_sent++;
    endtask

    // Idle point for a register write: all rows in, trailing store done
    task automatic settle();
        i_start <= 1'b0;
        @(negedge i_clk);
        while (board.rows_due.size() != 0) @(negedge i_clk);
        repeat (STORE_SETTLE) @(negedge i_clk);
        while (o_busy) @(negedge i_clk);
    endtask

    task automatic write_correction(t_stamp v);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        board.correction = v;
    endtask

    // Monitor: score row transfers, note item transfers, watchdog on the input side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            if (o_strobe) board.check_row(o_result);
            if (i_start && !o_busy) board.note_item(i_item);
            if ((i_start && !o_busy) || i_cfg_we) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("simulation failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        int     run;
        int     random_base;
        longint cur;
        longint t1;
        longint t2;
        t_stamp corr_plan [PHASES];

        board      = new();
        burst_left = 0;
        items_sent = 0;
        raw_next   = 0;
        i_rst_n    = 1'b0;
        i_start    = 1'b0;
        i_item     = '0;
        i_cfg_we   = 1'b0;
        i_cfg_data = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: empty ring and inverted window
        send_item(KIND_QUERY, 48'sd0, 48'sd10, rand_words());
        send_item(KIND_QUERY, STAMP_MAX, STAMP_MIN, rand_words());
        // Four samples, sensor word extremes first
        send_item(KIND_STORE, 48'sd2000000, rand_stamp(), {SENSOR_WORDS{32'h7fffffff}});
        send_item(KIND_STORE, 48'sd2010000, rand_stamp(), {SENSOR_WORDS{32'h80000000}});
        send_item(KIND_STORE, 48'sd2020000, rand_stamp(), rand_words());
        send_item(KIND_STORE, 48'sd2030000, rand_stamp(), rand_words());
        // Start past one second with an empty slot ahead of the oldest sample
        send_item(KIND_QUERY, 48'sd1500000, 48'sd2015000, rand_words());
        // Start below one second: begins at the first sample
        send_item(KIND_QUERY, 48'sd500000, 48'sd2000000, rand_words());
        // Window past the newest sample: single row
        send_item(KIND_QUERY, 48'sd3000000, 48'sd4000000, rand_words());
        send_item(KIND_QUERY, 48'sd2010000, STAMP_MAX, rand_words());
        send_item(KIND_QUERY, STAMP_MIN, STAMP_MAX, rand_words());
        send_item(KIND_STORE, -48'sd5, rand_stamp(), rand_words());
        send_item(KIND_QUERY, -48'sd10, -48'sd10, rand_words());

        // Saturation at both ends of the stamp range
        settle();
        write_correction(STAMP_MAX);
        send_item(KIND_STORE, 48'sd100, rand_stamp(), rand_words());
        send_item(KIND_STORE, STAMP_MAX, rand_stamp(), rand_words());
        settle();
        write_correction(STAMP_MIN);
        send_item(KIND_STORE, STAMP_MIN, rand_stamp(), rand_words());
        send_item(KIND_STORE, 48'sd0, rand_stamp(), rand_words());
        send_item(KIND_STORE, STAMP_MAX, rand_stamp(), rand_words());
        send_item(KIND_QUERY, STAMP_MIN, STAMP_MIN, rand_words());
        send_item(KIND_QUERY, STAMP_MAX, STAMP_MAX, rand_words());

        // Random phases, one correction setting each
        corr_plan[0] = to_stamp(longint'($urandom_range(0, 100000)) - 64'sd50000);
        corr_plan[1] = STAMP_MAX;
        corr_plan[2] = rand_stamp();
        corr_plan[3] = STAMP_MIN;
        corr_plan[4] = '0;
        corr_plan[5] = to_stamp(-longint'($urandom_range(1, 2000000)));
        random_base  = items_sent;
        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            write_correction(corr_plan[ph]);
            case ($urandom_range(0, 3))
                0: raw_next = longint'($urandom_range(0, 300000));
                1: raw_next = longint'($urandom) << 14;
                2: raw_next = -(longint'($urandom) << 14);
                default: ;
            endcase
            while (items_sent < random_base + (ph + 1) * RANDOM_ITEMS / PHASES) begin
                if ($urandom_range(0, 9) == 0) begin
                    // Noise: any kind, any stamps
                    send_item($urandom_range(0, 1) == 1 ? KIND_QUERY : KIND_STORE,
                              rand_stamp(), rand_stamp(), rand_words());
                end else begin
                    // Run of rising samples, then a window over them
                    run = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 90)
                                                      : $urandom_range(1, 8);
                    repeat (run) begin
                        raw_next += longint'($urandom_range(0, 20000));
                        send_item(KIND_STORE, to_stamp(raw_next), rand_stamp(), rand_words());
                    end
                    cur = longint'(to_stamp(raw_next + longint'(board.correction)));
                    case ($urandom_range(0, 5))
                        0, 1: begin
                            t1 = cur - longint'($urandom_range(0, 400000));
                            t2 = t1 + longint'($urandom_range(0, 150000));
                        end
                        2: begin
                            // Most or all of the ring
                            t1 = cur - longint'($urandom_range(600000, 1300000));
                            t2 = cur + longint'($urandom_range(0, 50000));
                        end
                        3: begin
                            // Below the oldest sample
                            t1 = longint'(STAMP_MIN) + longint'($urandom_range(0, 1000));
                            t2 = t1 + longint'($urandom_range(0, 1000));
                        end
                        4: begin
                            t1 = cur + longint'($urandom_range(1, 100000));
                            t2 = t1 + longint'($urandom_range(0, 100000));
                        end
                        default: begin
                            t1 = cur - longint'($urandom_range(0, 200000));
                            t2 = t1 - longint'($urandom_range(1, 50000));
                        end
                    endcase
                    send_item(KIND_QUERY, to_stamp(t1), to_stamp(t2), rand_words());
                end
            end
        end

        // Drain and finish
        i_start <= 1'b0;
        while (board.rows_due.size() != 0) @(negedge i_clk);
        repeat (END_SETTLE) @(negedge i_clk);
        if (board.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== timestamped_sample_ring_window_core.f =====
+incdir+rtl
rtl/tsrw_pkg.sv
rtl/timestamped_sample_ring_window_core.sv
tb/timestamped_sample_ring_window_core_tb.sv
